// File: hdl/muon_variable_cone_isolation_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the muon variable-cone isolation unit
// Each macro expects clk and arst_n in the scope of the module that uses it.
// ---------------------------------------------------------------------------
`ifndef MUON_VARIABLE_CONE_ISOLATION_UNIT_DEFINES_SVH
`define MUON_VARIABLE_CONE_ISOLATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MVCI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define MVCI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define MVCI_ASSERT_IMP(label, ante, cons)
`define MVCI_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: hdl/mvci_pkg.sv
// ---------------------------------------------------------------------------
// mvci_pkg
// Widths, constants and shared types of the muon variable-cone isolation unit.
// ---------------------------------------------------------------------------
package mvci_pkg;

	// item field widths
	localparam int PT_W       = 16;
	localparam int ETA_W      = 13;
	localparam int PHI_W      = 13;
	localparam int PID_W      = 16;
	localparam int SUM_OUT_W  = 24;
	localparam int CMAX_W     = 11;
	localparam int FRAC_W     = 8;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// running sum width default
	localparam int SUM_WIDTH_DEF = 24;

	// phi wrap, 1/1024 rad
	localparam int PHI_PI     = 3217;
	localparam int PHI_TWO_PI = 6434;

	// cone arithmetic widths
	localparam int DETA_W    = ETA_W + 1;      // eta and phi differences
	localparam int DETA_SQ_W = 26;             // 8191^2 < 2^26
	localparam int DPHI_SQ_W = 24;             // 3217^2 < 2^24
	localparam int DSUM_W    = DETA_SQ_W + 1;
	localparam int D2_W      = 2 * CMAX_W;     // d2 below cone_max^2
	localparam int PTSQ_W    = 2 * PT_W;
	localparam int PROD_W    = D2_W + PTSQ_W;

	// queue between classifier and accumulator
	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MUON_PT_MIN     = 3'd0,
		CFG_MUON_ETA_MAX    = 3'd1,
		CFG_TRACK_PT_MIN    = 3'd2,
		CFG_CONE_MAX        = 3'd3,
		CFG_CONE_SCALE      = 3'd4,
		CFG_ISO_NUMERATOR   = 3'd5,
		CFG_ISO_DENOMINATOR = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [PT_W-1:0]   muon_pt_min;
		logic [ETA_W-1:0]  muon_eta_max;
		logic [PT_W-1:0]   track_pt_min;
		logic [CMAX_W-1:0] cone_max;
		logic [PT_W-1:0]   cone_scale;
		logic [FRAC_W-1:0] iso_numerator;
		logic [FRAC_W-1:0] iso_denominator;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		muon_pt_min:     16'd80,
		muon_eta_max:    13'd2560,
		track_pt_min:    16'd4,
		cone_max:        11'd307,
		cone_scale:      16'd40960,
		iso_numerator:   8'd3,
		iso_denominator: 8'd20
	};

	// classified item, front to back
	typedef struct packed {
		logic            is_track;
		logic [PT_W-1:0] pt;
		logic            counted;
		logic            kin;
		logic            last;
	} q_entry_t;

endpackage

// File: hdl/mvci_if.sv
// ---------------------------------------------------------------------------
// mvci_in_if / mvci_out_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface mvci_in_if;
	import mvci_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [PT_W-1:0]          pt;
	logic signed [ETA_W-1:0]  eta;
	logic signed [PHI_W-1:0]  phi;
	logic [PID_W-1:0]         particle_id;
	logic                     last;

	modport source (output valid, cmd, pt, eta, phi, particle_id, last, input ready);
	modport sink   (input valid, cmd, pt, eta, phi, particle_id, last, output ready);
endinterface

interface mvci_out_if;
	import mvci_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 selected;
	logic                 kinematics_ok;
	logic                 isolated;
	logic [SUM_OUT_W-1:0] track_pt_sum;
	logic                 sum_saturated;

	modport source (output valid, selected, kinematics_ok, isolated, track_pt_sum,
		sum_saturated, input ready);
	modport sink   (input valid, selected, kinematics_ok, isolated, track_pt_sum,
		sum_saturated, output ready);
endinterface

// File: hdl/mvci_queue.sv
// ---------------------------------------------------------------------------
// mvci_queue
// Short FIFO of classified items between the classifier and the accumulator.
// ---------------------------------------------------------------------------
`include "muon_variable_cone_isolation_unit_defines.svh"

module mvci_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mvci_pkg::q_entry_t     push_entry,
	input  logic                   pop,
	output mvci_pkg::q_entry_t     head,
	output logic                   head_valid,
	output logic [mvci_pkg::Q_CW-1:0] count
);
	import mvci_pkg::*;

	q_entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	// credit scheme upstream must never overrun the queue
	`MVCI_ASSERT_IMP(a_no_overflow, push, count_q < Q_CW'(Q_DEPTH))
	`MVCI_ASSERT_IMP(a_no_underflow, pop, count_q != '0)

endmodule

// File: hdl/mvci_front.sv
// ---------------------------------------------------------------------------
// mvci_front
// Accepts items, holds the candidate, and classifies each track through a
// four-stage cone test; pushes one classified item per accepted item.
// ---------------------------------------------------------------------------
`include "muon_variable_cone_isolation_unit_defines.svh"

module mvci_front (
	input  logic                       clk,
	input  logic                       arst_n,
	mvci_in_if.sink                    item_in,
	input  mvci_pkg::cfg_t             cfg,
	input  logic [mvci_pkg::Q_CW-1:0]  q_count,
	output logic                       push,
	output mvci_pkg::q_entry_t         push_entry
);
	import mvci_pkg::*;

	typedef struct packed {
		logic            is_track;
		logic [PT_W-1:0] pt;
		logic            last;
		logic            kin;
		logic            sel_ok;
		logic            cpt_zero;
	} tag_t;

	localparam logic signed [DETA_W-1:0] PI_S     = DETA_W'(PHI_PI);
	localparam logic signed [DETA_W-1:0] NEG_PI_S = -DETA_W'(PHI_PI);
	localparam logic signed [DETA_W-1:0] TWO_PI_S = DETA_W'(PHI_TWO_PI);

	// candidate state
	logic [PT_W-1:0]         cand_pt_q;
	logic signed [ETA_W-1:0] cand_eta_q;
	logic signed [PHI_W-1:0] cand_phi_q;
	logic [PID_W-1:0]        cand_pid_q;
	logic                    cand_kin_q;

	// squared cone limits, refreshed every cycle
	logic [D2_W-1:0]   cmax_sq_q;
	logic [PTSQ_W-1:0] cs_sq_q;

	logic accept;
	logic [Q_CW:0] level;

	logic signed [DETA_W-1:0] eta_ext, phi_ext, cand_eta_ext, cand_phi_ext;
	logic signed [DETA_W-1:0] deta_c, dphi_raw, dphi_c, eta_abs;
	logic kin_new;
	tag_t tag_c;

	logic v_s1, v_s2, v_s3, v_s4;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [DETA_W-1:0] deta_s1;
	logic signed [PHI_W-1:0]  dphi_s1;
	logic [PT_W-1:0]          cpt_s1;

	logic signed [2*DETA_W-1:0] deta_sq_c;
	logic signed [2*PHI_W-1:0]  dphi_sq_c;
	logic [DETA_SQ_W-1:0] deta_sq_s2;
	logic [DPHI_SQ_W-1:0] dphi_sq_s2;
	logic [PTSQ_W-1:0]    ptsq_s2;

	logic [DSUM_W-1:0] d2_c;
	logic              near_c;
	logic [D2_W-1:0]   d2_s3;
	logic              near_s3;
	logic [PTSQ_W-1:0] ptsq_s3;

	logic [PROD_W-1:0] prod_s4;
	logic              near_s4;
	logic              cone_ok;

	// input credit: queue fill plus items still in the pipeline
	assign level = (Q_CW+1)'(q_count) + (Q_CW+1)'($countones({v_s1, v_s2, v_s3, v_s4}));
	assign item_in.ready = (level < (Q_CW+1)'(Q_DEPTH));
	assign accept = item_in.valid && item_in.ready;

	always_comb begin
		eta_ext      = {item_in.eta[ETA_W-1], item_in.eta};
		phi_ext      = {item_in.phi[PHI_W-1], item_in.phi};
		cand_eta_ext = {cand_eta_q[ETA_W-1], cand_eta_q};
		cand_phi_ext = {cand_phi_q[PHI_W-1], cand_phi_q};
		deta_c       = eta_ext - cand_eta_ext;
		dphi_raw     = phi_ext - cand_phi_ext;
		// one wrap step brings any 13-bit difference within plus minus pi
		if (dphi_raw > PI_S) begin
			dphi_c = dphi_raw - TWO_PI_S;
		end else if (dphi_raw < NEG_PI_S) begin
			dphi_c = dphi_raw + TWO_PI_S;
		end else begin
			dphi_c = dphi_raw;
		end
		eta_abs = eta_ext[DETA_W-1] ? -eta_ext : eta_ext;
		kin_new = (item_in.pt > cfg.muon_pt_min) &&
			(eta_abs < signed'({1'b0, cfg.muon_eta_max}));
		tag_c.is_track = item_in.cmd;
		tag_c.pt       = item_in.pt;
		tag_c.last     = item_in.last;
		tag_c.kin      = kin_new;
		tag_c.sel_ok   = (item_in.pt > cfg.track_pt_min) && (item_in.particle_id != cand_pid_q);
		tag_c.cpt_zero = (cand_pt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_pt_q  <= '0;
			cand_eta_q <= '0;
			cand_phi_q <= '0;
			cand_pid_q <= '0;
			cand_kin_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
		end else begin
			if (accept && !item_in.cmd) begin
				cand_pt_q  <= item_in.pt;
				cand_eta_q <= item_in.eta;
				cand_phi_q <= item_in.phi;
				cand_pid_q <= item_in.particle_id;
				cand_kin_q <= kin_new;
			end
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign deta_sq_c = deta_s1 * deta_s1;
	assign dphi_sq_c = dphi_s1 * dphi_s1;
	assign d2_c      = DSUM_W'(deta_sq_s2) + DSUM_W'(dphi_sq_s2);
	assign near_c    = d2_c < DSUM_W'(cmax_sq_q);

	always_ff @(posedge clk) begin
		cmax_sq_q <= cfg.cone_max * cfg.cone_max;
		cs_sq_q   <= cfg.cone_scale * cfg.cone_scale;

		// stage 1: differences
		tag_s1  <= tag_c;
		deta_s1 <= deta_c;
		dphi_s1 <= dphi_c[PHI_W-1:0];
		cpt_s1  <= cand_pt_q;

		// stage 2: squares
		tag_s2     <= tag_s1;
		deta_sq_s2 <= deta_sq_c[DETA_SQ_W-1:0];
		dphi_sq_s2 <= dphi_sq_c[DPHI_SQ_W-1:0];
		ptsq_s2    <= cpt_s1 * cpt_s1;

		// stage 3: distance and fixed cone
		tag_s3  <= tag_s2;
		d2_s3   <= d2_c[D2_W-1:0];
		near_s3 <= near_c;
		ptsq_s3 <= ptsq_s2;

		// stage 4: momentum-scaled distance
		tag_s4  <= tag_s3;
		prod_s4 <= d2_s3 * ptsq_s3;
		near_s4 <= near_s3;
	end

	assign cone_ok = near_s4 && (tag_s4.cpt_zero || (prod_s4 < PROD_W'(cs_sq_q)));

	assign push                = v_s4;
	assign push_entry.is_track = tag_s4.is_track;
	assign push_entry.pt       = tag_s4.pt;
	assign push_entry.counted  = tag_s4.is_track && tag_s4.sel_ok && cone_ok;
	assign push_entry.kin      = tag_s4.kin;
	assign push_entry.last     = tag_s4.last;

	// a passing candidate always has nonzero pT
	`MVCI_ASSERT_IMP(a_kin_pt_nonzero, cand_kin_q, cand_pt_q != '0)
	// every accepted item enters pipeline stage 1, then moves through stages 2 to 4 to the queue
	`MVCI_ASSERT_NXT(a_s1_follows_accept, accept, v_s1)

endmodule

// File: hdl/mvci_back.sv
// ---------------------------------------------------------------------------
// mvci_back
// Pops classified items, keeps the saturating track sum, and forms one
// result per last item through a product stage and an output register.
// ---------------------------------------------------------------------------
`include "muon_variable_cone_isolation_unit_defines.svh"

module mvci_back #(
	parameter int SUM_WIDTH = mvci_pkg::SUM_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mvci_pkg::q_entry_t  head,
	input  logic                head_valid,
	output logic                pop,
	input  mvci_pkg::cfg_t      cfg,
	mvci_out_if.source          result_out
);
	import mvci_pkg::*;

	localparam int PW = SUM_WIDTH + FRAC_W;
	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

	logic [SUM_WIDTH-1:0] sum_q;
	logic                 sat_q;
	logic                 kin_q;
	logic [PT_W-1:0]      cpt_q;

	logic [SUM_WIDTH:0]   sum_add;
	logic                 sat_hit;
	logic [SUM_WIDTH-1:0] sum_d;
	logic                 sat_d, kin_d;
	logic [PT_W-1:0]      cpt_d;

	logic                 v_s1, v_s2;
	logic [SUM_WIDTH-1:0] sum_s1;
	logic                 sat_s1, kin_s1;
	logic [PT_W-1:0]      cpt_s1;
	logic [SUM_OUT_W-1:0] sum24_c;

	logic [PW-1:0]          sumden_s2;
	logic [PT_W+FRAC_W-1:0] numpt_s2;
	logic                   sat_s2, kin_s2;
	logic [SUM_OUT_W-1:0]   sum24_s2;

	logic                 ovalid_q;
	logic                 sel_q, kin_out_q, iso_q, osat_q;
	logic [SUM_OUT_W-1:0] osum_q;

	logic out_free, adv2, s2_free, adv1, s1_free, iso_c;

	assign out_free = !ovalid_q || result_out.ready;
	assign adv2     = v_s2 && out_free;
	assign s2_free  = !v_s2 || adv2;
	assign adv1     = v_s1 && s2_free;
	assign s1_free  = !v_s1 || adv1;
	// a last item leaves the queue only when the result stage has room
	assign pop      = head_valid && (!head.last || s1_free);

	always_comb begin
		sum_add = {1'b0, sum_q} + (SUM_WIDTH+1)'(head.pt);
		sat_hit = (sum_add >= {1'b0, SUM_MAX});
		sum_d   = sum_q;
		sat_d   = sat_q;
		kin_d   = kin_q;
		cpt_d   = cpt_q;
		if (!head.is_track) begin
			sum_d = '0;
			sat_d = 1'b0;
			kin_d = head.kin;
			cpt_d = head.pt;
		end else if (head.counted) begin
			sum_d = sat_hit ? SUM_MAX : sum_add[SUM_WIDTH-1:0];
			sat_d = sat_q || sat_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			sat_q    <= 1'b0;
			kin_q    <= 1'b0;
			cpt_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				sum_q <= sum_d;
				sat_q <= sat_d;
				kin_q <= kin_d;
				cpt_q <= cpt_d;
			end
			v_s1     <= (v_s1 && !adv1) || (pop && head.last);
			v_s2     <= (v_s2 && !adv2) || adv1;
			ovalid_q <= (ovalid_q && !result_out.ready) || adv2;
		end
	end

	generate
		if (SUM_WIDTH >= SUM_OUT_W) begin : g_sum_trunc
			assign sum24_c = sum_s1[SUM_OUT_W-1:0];
		end else begin : g_sum_ext
			assign sum24_c = {{(SUM_OUT_W-SUM_WIDTH){1'b0}}, sum_s1};
		end
	endgenerate

	assign iso_c = sumden_s2 < PW'(numpt_s2);

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			sum_s1 <= sum_d;
			sat_s1 <= sat_d;
			kin_s1 <= kin_d;
			cpt_s1 <= cpt_d;
		end
		if (adv1) begin
			sumden_s2 <= sum_s1 * cfg.iso_denominator;
			numpt_s2  <= cfg.iso_numerator * cpt_s1;
			sat_s2    <= sat_s1;
			kin_s2    <= kin_s1;
			sum24_s2  <= sum24_c;
		end
		if (adv2) begin
			sel_q     <= kin_s2 && iso_c;
			kin_out_q <= kin_s2;
			iso_q     <= iso_c;
			osum_q    <= sum24_s2;
			osat_q    <= sat_s2;
		end
	end

	assign result_out.valid         = ovalid_q;
	assign result_out.selected      = sel_q;
	assign result_out.kinematics_ok = kin_out_q;
	assign result_out.isolated      = iso_q;
	assign result_out.track_pt_sum  = osum_q;
	assign result_out.sum_saturated = osat_q;

	// the sticky flag only stands with a clamped sum
	`MVCI_ASSERT_IMP(a_sat_means_max, sat_q, sum_q == SUM_MAX)
	// a waiting product stage holds while the output register is blocked
	`MVCI_ASSERT_NXT(a_s2_holds, v_s2 && !out_free, v_s2)

endmodule

// File: hdl/muon_variable_cone_isolation_unit.sv
// ---------------------------------------------------------------------------
// muon_variable_cone_isolation_unit
// Muon candidate selection with track isolation in a pT-dependent cone.
// ---------------------------------------------------------------------------
// Usage:
//   item_in carries one item per handshake: cmd = 0 opens a muon candidate,
//   cmd = 1 is a track tested against the open candidate. An item with
//   last = 1 closes the run and yields one item on result_out: kinematic
//   pass, isolation, selection, the saturating track pT sum and its flag.
//   Registers are written through cfg_we / cfg_index / cfg_wdata while the
//   block is idle; index 7 is ignored.
// Data path:
//   One item enters per cycle while item_in.ready is high. A last item
//   passes through the cone classification stages (differences, squares,
//   distance, momentum scaling), the queue, then the sum snapshot, the
//   isolation product stage and the output register to result_out. The
//   classifier pipeline takes a new track every cycle while ready is high,
//   and the back end updates the sum once for each item it pops.
// Reset and stall:
//   arst_n clears the candidate, the sum, the queue and all valid bits and
//   loads the register defaults. When result_out stalls, the result stages
//   hold, the 8-entry queue fills, and item_in.ready drops once queue fill
//   plus items in flight reaches the queue depth; nothing is dropped.
// ---------------------------------------------------------------------------
module muon_variable_cone_isolation_unit #(
	parameter int SUM_WIDTH = mvci_pkg::SUM_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	mvci_in_if.sink                           item_in,
	mvci_out_if.source                        result_out,
	input  logic                              cfg_we,
	input  logic [mvci_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mvci_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import mvci_pkg::*;

	cfg_t              cfg_q;
	logic              push;
	q_entry_t          push_entry;
	logic              pop;
	q_entry_t          head;
	logic              head_valid;
	logic [Q_CW-1:0]   q_count;

	// register file: write only, masked to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MUON_PT_MIN:     cfg_q.muon_pt_min     <= cfg_wdata[PT_W-1:0];
				CFG_MUON_ETA_MAX:    cfg_q.muon_eta_max    <= cfg_wdata[ETA_W-1:0];
				CFG_TRACK_PT_MIN:    cfg_q.track_pt_min    <= cfg_wdata[PT_W-1:0];
				CFG_CONE_MAX:        cfg_q.cone_max        <= cfg_wdata[CMAX_W-1:0];
				CFG_CONE_SCALE:      cfg_q.cone_scale      <= cfg_wdata[PT_W-1:0];
				CFG_ISO_NUMERATOR:   cfg_q.iso_numerator   <= cfg_wdata[FRAC_W-1:0];
				CFG_ISO_DENOMINATOR: cfg_q.iso_denominator <= cfg_wdata[FRAC_W-1:0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	// front: accept, hold the candidate, classify tracks
	mvci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.cfg        (cfg_q),
		.q_count    (q_count),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	mvci_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (q_count)
	);

	// back: accumulate and report
	mvci_back #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.cfg        (cfg_q),
		.result_out (result_out)
	);

endmodule

// File: bench/muon_variable_cone_isolation_unit_tb.sv
// ---------------------------------------------------------------------------
// muon_variable_cone_isolation_unit_tb
// Self-checking bench for the muon variable-cone isolation unit. Muon
// candidates and their track runs go in through the item channel, while an
// in-bench model of the selection computes every verdict that a closing item
// should produce. Each verdict that comes out is checked field by field
// against the oldest prediction. Both channels idle and stall at random, and
// the cut registers are reloaded between phases while the unit is quiet.
// ---------------------------------------------------------------------------
module muon_variable_cone_isolation_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mvci_pkg::*;

	// item opcodes
	localparam bit CMD_CANDIDATE = 1'b0;
	localparam bit CMD_TRACK     = 1'b1;

	// closing item to verdict, unstalled
	localparam int PIPE_LATENCY   = 7;
	// cycles with no handshake on either channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 2000;
	localparam longint SUM_CEILING = (longint'(1) << SUM_WIDTH_DEF) - 1;

	typedef struct packed {
		logic                    cmd;
		logic [PT_W-1:0]         pt;
		logic signed [ETA_W-1:0] eta;
		logic signed [PHI_W-1:0] phi;
		logic [PID_W-1:0]        particle_id;
		logic                    last;
	} stream_item_t;

	typedef struct packed {
		logic                 selected;
		logic                 kinematics_ok;
		logic                 isolated;
		logic [SUM_OUT_W-1:0] track_pt_sum;
		logic                 sum_saturated;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mvci_in_if  item_if();
	mvci_out_if verdict_if();

	muon_variable_cone_isolation_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (verdict_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Selection model: cut registers, the open candidate and its track sum.
	// -----------------------------------------------------------------------
	cfg_t                    cuts = CFG_RESET;
	logic [PT_W-1:0]         muon_pt;
	logic signed [ETA_W-1:0] muon_eta;
	logic signed [PHI_W-1:0] muon_phi;
	logic [PID_W-1:0]        muon_pid;
	bit                      muon_kin_pass;
	longint                  cone_pt_sum;
	bit                      cone_sum_clamped;

	// verdicts owed by the unit, oldest first
	verdict_t pending_verdicts[$];

	int items_sent;
	int verdicts_checked;
	int selected_seen;
	int saturated_seen;
	int cut_settings;
	int mismatches;
	int burst_left;
	int idle_cycles;
	int stall_tick;
	int stall_mode;
	int stall_hold;

	// Cone test without division: the distance must be inside the fixed
	// maximum radius and, for a nonzero candidate pT, inside cone_scale / pT.
	function automatic bit cone_hit(logic signed [ETA_W-1:0] eta,
		logic signed [PHI_W-1:0] phi);
		longint deta, dphi, d2, cmax, scale, cpt;
		deta = longint'(eta) - longint'(muon_eta);
		dphi = longint'(phi) - longint'(muon_phi);
		// fold the azimuth difference back into plus minus pi
		while (dphi > PHI_PI)
			dphi -= PHI_TWO_PI;
		while (dphi < -PHI_PI)
			dphi += PHI_TWO_PI;
		d2 = deta * deta + dphi * dphi;
		cmax = longint'(cuts.cone_max);
		scale = longint'(cuts.cone_scale);
		cpt = longint'(muon_pt);
		if (!(d2 < cmax * cmax))
			return 1'b0;
		// a zero-pT candidate means an unbounded scaled radius
		if (cpt != 0 && !(d2 * cpt * cpt < scale * scale))
			return 1'b0;
		return 1'b1;
	endfunction

	// Advance the model by one accepted item; a closing item owes a verdict.
	task automatic predict_isolation(input stream_item_t it);
		longint abs_eta, total;
		bit iso;
		verdict_t v;
		if (it.cmd == CMD_CANDIDATE) begin
			abs_eta = longint'(it.eta);
			if (abs_eta < 0)
				abs_eta = -abs_eta;
			muon_pt = it.pt;
			muon_eta = it.eta;
			muon_phi = it.phi;
			muon_pid = it.particle_id;
			muon_kin_pass = (longint'(it.pt) > longint'(cuts.muon_pt_min)) &&
				(abs_eta < longint'(cuts.muon_eta_max));
			cone_pt_sum = 0;
			cone_sum_clamped = 1'b0;
		end else if (longint'(it.pt) > longint'(cuts.track_pt_min) &&
			it.particle_id != muon_pid && cone_hit(it.eta, it.phi)) begin
			// clamp at the top of the sum and make the flag stick
			total = cone_pt_sum + longint'(it.pt);
			if (total >= SUM_CEILING) begin
				total = SUM_CEILING;
				cone_sum_clamped = 1'b1;
			end
			cone_pt_sum = total;
		end
		if (!it.last)
			return;
		// taken literally, so a zero denominator still compares
		iso = cone_pt_sum * longint'(cuts.iso_denominator) <
			longint'(cuts.iso_numerator) * longint'(muon_pt);
		v.selected = muon_kin_pass && iso;
		v.kinematics_ok = muon_kin_pass;
		v.isolated = iso;
		v.track_pt_sum = cone_pt_sum[SUM_OUT_W-1:0];
		v.sum_saturated = cone_sum_clamped;
		pending_verdicts.insert(pending_verdicts.size(), v);
	endtask

	// -----------------------------------------------------------------------
	// Item side: bursts of random length separated by random gaps.
	// Drive on the falling edge, take the handshake at the rising edge.
	// -----------------------------------------------------------------------
	task automatic push_item(input stream_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 3);
				2: gap = $urandom_range(4, 12);
				default: gap = $urandom_range(0, 1);
			endcase
			if (gap > 0) begin
				@(negedge clk);
				item_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		item_if.valid <= 1'b1;
		item_if.cmd <= it.cmd;
		item_if.pt <= it.pt;
		item_if.eta <= it.eta;
		item_if.phi <= it.phi;
		item_if.particle_id <= it.particle_id;
		item_if.last <= it.last;
		do
			@(posedge clk);
		while (!item_if.ready);
		predict_isolation(it);
		items_sent++;
	endtask

	function automatic stream_item_t make_item(bit cmd, int pt, int eta, int phi,
		int pid, bit last);
		stream_item_t it;
		it.cmd = cmd;
		it.pt = pt[PT_W-1:0];
		it.eta = eta[ETA_W-1:0];
		it.phi = phi[PHI_W-1:0];
		it.particle_id = pid[PID_W-1:0];
		it.last = last;
		return it;
	endfunction

	function automatic int clamp13(int v);
		if (v > 4095)
			return 4095;
		if (v < -4096)
			return -4096;
		return v;
	endfunction

	// Hold the item side low until every owed verdict is in and the
	// back end has had time to finish tracks that owe nothing.
	task automatic drain_pipeline();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic write_cut(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
	endtask

	// Load all seven cut registers while the unit is quiet.
	task automatic apply_cuts(input cfg_t c);
		drain_pipeline();
		write_cut(CFG_MUON_PT_MIN, c.muon_pt_min);
		write_cut(CFG_MUON_ETA_MAX, CFG_DATA_W'(c.muon_eta_max));
		write_cut(CFG_TRACK_PT_MIN, c.track_pt_min);
		write_cut(CFG_CONE_MAX, CFG_DATA_W'(c.cone_max));
		write_cut(CFG_CONE_SCALE, c.cone_scale);
		write_cut(CFG_ISO_NUMERATOR, CFG_DATA_W'(c.iso_numerator));
		write_cut(CFG_ISO_DENOMINATOR, CFG_DATA_W'(c.iso_denominator));
		@(negedge clk);
		cfg_we <= 1'b0;
		cuts = c;
		cut_settings++;
	endtask

	// Mostly typical values, with the given low and high bounds now and then.
	function automatic int pick_cut(int lo, int hi, int typ_lo, int typ_hi);
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			default: return $urandom_range(typ_lo, typ_hi);
		endcase
	endfunction

	function automatic cfg_t random_cuts();
		cfg_t c;
		c.muon_pt_min = PT_W'(pick_cut(0, 65535, 0, 400));
		c.muon_eta_max = ETA_W'(pick_cut(0, 4096, 500, 3500));
		c.track_pt_min = PT_W'(pick_cut(0, 65535, 0, 40));
		c.cone_max = CMAX_W'(pick_cut(0, 1024, 50, 700));
		c.cone_scale = PT_W'(pick_cut(0, 65535, 5000, 65535));
		c.iso_numerator = FRAC_W'(pick_cut(0, 255, 1, 40));
		c.iso_denominator = FRAC_W'(pick_cut(0, 255, 1, 40));
		return c;
	endfunction

	// One candidate and its tracks. Tracks scatter around the candidate so
	// that the cone test goes both ways; some share its particle id. With
	// close low the run stays open and later items keep adding to it.
	task automatic send_candidate_run(input int n_tracks, input bit close);
		int c_pt, c_eta, c_phi, c_pid, t_pt, t_eta, t_phi, t_pid, reach;
		case ($urandom_range(0, 7))
			0: c_pt = $urandom_range(0, 65535);
			1: c_pt = 0;
			default: c_pt = $urandom_range(0, 800);
		endcase
		if ($urandom_range(0, 7) == 0)
			c_eta = int'($urandom_range(0, 8191)) - 4096;
		else
			c_eta = int'($urandom_range(0, 6000)) - 3000;
		// favor azimuth near the seam so the wrap gets exercised
		case ($urandom_range(0, 5))
			0: c_phi = int'($urandom_range(0, 8191)) - 4096;
			1, 2: c_phi = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(2900, 3217));
			default: c_phi = int'($urandom_range(0, 6434)) - 3217;
		endcase
		c_pid = $urandom_range(0, 65535);
		push_item(make_item(CMD_CANDIDATE, c_pt, c_eta, c_phi, c_pid,
			close && n_tracks == 0));
		reach = $urandom_range(40, 600);
		for (int i = 0; i < n_tracks; i++) begin
			t_pt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
				$urandom_range(0, 80);
			t_eta = clamp13(c_eta + int'($urandom_range(0, 2 * reach)) - reach);
			t_phi = c_phi + int'($urandom_range(0, 2 * reach)) - reach;
			if ($urandom_range(0, 3) != 0) begin
				if (t_phi > PHI_PI)
					t_phi -= PHI_TWO_PI;
				else if (t_phi < -PHI_PI)
					t_phi += PHI_TWO_PI;
			end
			t_phi = clamp13(t_phi);
			t_pid = ($urandom_range(0, 7) == 0) ? c_pid : $urandom_range(0, 65535);
			push_item(make_item(CMD_TRACK, t_pt, t_eta, t_phi, t_pid,
				close && i == n_tracks - 1));
		end
	endtask

	// Items with every field drawn over its full width.
	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			push_item(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
				int'($urandom_range(0, 8191)) - 4096,
				int'($urandom_range(0, 8191)) - 4096,
				$urandom_range(0, 65535), $urandom_range(0, 3) == 0));
	endtask

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Reset cuts: 80 / 2560 / 4 / 307 / 40960 / 3 / 20.
	task automatic test_reset_cuts_directed();
		// track before any candidate meets the all-zero candidate state
		push_item(make_item(CMD_TRACK, 10, 0, 0, 5, 1'b1));
		// candidate that closes at once: empty sum
		push_item(make_item(CMD_CANDIDATE, 400, 100, 0, 7, 1'b1));
		// candidate just inside both kinematic cuts, near the phi seam
		push_item(make_item(CMD_CANDIDATE, 81, -2559, 3200, 9, 1'b0));
		push_item(make_item(CMD_TRACK, 5, -2559, -3200, 10, 1'b0));   // wraps, counts
		push_item(make_item(CMD_TRACK, 50, -2559, 3200, 9, 1'b0));    // same particle
		push_item(make_item(CMD_TRACK, 4, -2559, 3200, 11, 1'b0));    // at track cut
		push_item(make_item(CMD_TRACK, 30, -2000, 3200, 12, 1'b0));   // out of cone
		push_item(make_item(CMD_TRACK, 6, -2500, 3217, 13, 1'b1));
		// tracks after the closing item still add to the same sum
		push_item(make_item(CMD_TRACK, 7, -2559, 3200, 14, 1'b0));
		push_item(make_item(CMD_TRACK, 8, -2559, 3200, 15, 1'b1));
		// candidate at the pT cut fails kinematics, isolation still reported
		push_item(make_item(CMD_CANDIDATE, 80, 0, 0, 1, 1'b0));
		push_item(make_item(CMD_TRACK, 2, 0, 0, 2, 1'b0));
		push_item(make_item(CMD_TRACK, 65535, 10, -10, 2, 1'b1));
		// field extremes, phi outside plus minus pi
		push_item(make_item(CMD_CANDIDATE, 65535, -4096, 4095, 65535, 1'b0));
		push_item(make_item(CMD_TRACK, 65535, 4095, -4096, 0, 1'b0));
		push_item(make_item(CMD_TRACK, 65535, -4096, 4095, 0, 1'b1));
		// eta at the limit, track a full turn away in phi
		push_item(make_item(CMD_CANDIDATE, 1000, -2560, -3217, 0, 1'b0));
		push_item(make_item(CMD_CANDIDATE, 1000, 2559, -3217, 0, 1'b0));
		push_item(make_item(CMD_TRACK, 0, 2559, -3217, 1, 1'b0));
		push_item(make_item(CMD_TRACK, 20, 2559, 3217, 1, 1'b1));
		// scaled cone edge: 40960 / 300 lies between 136 and 137
		push_item(make_item(CMD_CANDIDATE, 300, 0, 0, 3, 1'b0));
		push_item(make_item(CMD_TRACK, 100, 136, 0, 4, 1'b0));
		push_item(make_item(CMD_TRACK, 100, 137, 0, 4, 1'b1));
	endtask

	// Every register at its low end, then each at a high value, and a wide-open mix.
	task automatic test_cut_extremes();
		cfg_t c;
		for (int k = 0; k < 3; k++) begin
			case (k)
				0: c = '{16'd0, 13'd0, 16'd0, 11'd0, 16'd0, 8'd0, 8'd0};
				1: c = '{16'd65535, 13'd4096, 16'd65535, 11'd1024, 16'd65535,
					8'd255, 8'd255};
				default: c = '{16'd0, 13'd4096, 16'd0, 11'd1024, 16'd65535,
					8'd255, 8'd1};
			endcase
			apply_cuts(c);
			repeat (6) send_candidate_run($urandom_range(0, 6), 1'b1);
			send_noise(3);
			send_candidate_run($urandom_range(1, 4), 1'b1);
		end
	endtask

	// Drive the sum into its ceiling: once landing on it exactly, once past.
	task automatic test_sum_saturation();
		cfg_t c;
		c = CFG_RESET;
		c.track_pt_min = 16'd0;
		c.cone_max = 11'd1024;
		apply_cuts(c);
		// zero-pT candidate: only the fixed radius applies
		push_item(make_item(CMD_CANDIDATE, 0, 0, 0, 0, 1'b0));
		push_item(make_item(CMD_TRACK, 65535, 0, 0, 1, 1'b1));
		repeat (255) push_item(make_item(CMD_TRACK, 65535, 0, 0, 1, 1'b0));
		push_item(make_item(CMD_TRACK, 255, 0, 0, 1, 1'b1));
		push_item(make_item(CMD_TRACK, 65535, 0, 0, 1, 1'b0));
		push_item(make_item(CMD_TRACK, 65535, 0, 0, 1, 1'b1));
		// fresh candidate clears the flag, then overshoot the ceiling
		push_item(make_item(CMD_CANDIDATE, 0, 0, 0, 0, 1'b1));
		repeat (256) push_item(make_item(CMD_TRACK, 65535, 3, -3, 2, 1'b0));
		push_item(make_item(CMD_TRACK, 65535, 3, -3, 2, 1'b1));
		push_item(make_item(CMD_CANDIDATE, 500, 0, 0, 0, 1'b1));
	endtask

	// Phases of random cuts; mostly closed runs, some left open, some noise.
	task automatic test_random_runs();
		int phase_end;
		for (int p = 0; p < 5; p++) begin
			apply_cuts(random_cuts());
			phase_end = items_sent + 115;
			while (items_sent < phase_end) begin
				case ($urandom_range(0, 9))
					0: send_noise($urandom_range(1, 4));
					1: send_candidate_run($urandom_range(0, 8), 1'b0);
					2: send_candidate_run($urandom_range(20, 40), 1'b1);
					default: send_candidate_run($urandom_range(0, 12), 1'b1);
				endcase
			end
		end
	endtask

	// -----------------------------------------------------------------------
	// Verdict side
	// -----------------------------------------------------------------------

	// Stall on a pattern that switches between four modes:
	// always ready, random drops, a fixed duty cycle, or long holds.
	always @(negedge clk) begin : verdict_stall
		bit take;
		stall_tick++;
		if (stall_tick % 300 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: take = 1'b1;
			1: take = ($urandom_range(0, 3) != 0);
			2: take = ((stall_tick % 7) < 4);
			default: begin
				if (stall_hold > 0) begin
					stall_hold--;
					take = 1'b0;
				end else begin
					take = 1'b1;
					if ($urandom_range(0, 15) == 0)
						stall_hold = $urandom_range(4, 20);
				end
			end
		endcase
		verdict_if.ready <= take;
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Match every verdict against the oldest one owed.
	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (arst_n && verdict_if.valid && verdict_if.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("verdict with no closing item outstanding: sum %0d",
					verdict_if.track_pt_sum);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("selected", 32'(want.selected), 32'(verdict_if.selected));
				check_field("kinematics_ok", 32'(want.kinematics_ok),
					32'(verdict_if.kinematics_ok));
				check_field("isolated", 32'(want.isolated), 32'(verdict_if.isolated));
				check_field("track_pt_sum", 32'(want.track_pt_sum),
					32'(verdict_if.track_pt_sum));
				check_field("sum_saturated", 32'(want.sum_saturated),
					32'(verdict_if.sum_saturated));
			end
			verdicts_checked++;
			if (verdict_if.selected === 1'b1)
				selected_seen++;
			if (verdict_if.sum_saturated === 1'b1)
				saturated_seen++;
		end
	end

	// Abandon the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (verdict_if.valid && verdict_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake in %0d cycles", WATCHDOG_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		// hold every input at a known value through reset
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.cmd = CMD_CANDIDATE;
		item_if.pt = '0;
		item_if.eta = '0;
		item_if.phi = '0;
		item_if.particle_id = '0;
		item_if.last = 1'b0;
		verdict_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MUON_PT_MIN;
		cfg_wdata = '0;
		muon_pt = '0;
		muon_eta = '0;
		muon_phi = '0;
		muon_pid = '0;
		muon_kin_pass = 1'b0;
		cone_pt_sum = 0;
		cone_sum_clamped = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// the directed part relies on the reset values of the cut registers
		test_reset_cuts_directed();
		test_cut_extremes();
		test_sum_saturation();
		test_random_runs();

		drain_pipeline();
		$display("covered %0d items across %0d register settings plus the reset values",
			items_sent, cut_settings);
		$display("checked %0d verdicts: %0d selected, %0d with a saturated sum",
			verdicts_checked, selected_seen, saturated_seen);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
